FILE: hdl/jhtb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package jhtb_pkg;

   // Fast lookup geometry
   localparam int FAST_BITS = 9;
   localparam int FAST_SIZE = 1 << FAST_BITS;

   // Running sum of fast entries claimed by the counts of one table
   localparam int USED_W = FAST_BITS + 8;

   // Class byte checks
   localparam logic [7:0] CLASS_RESERVED = 8'hEC;
   localparam logic [7:0] CLASS_UNSUPP   = 8'h02;

   // Number of code-length counts in a table header
   localparam int NUM_LENGTHS = 16;

   // Most results one byte can cause: symbol, fill range, segment done
   localparam int MAX_RESULTS = 3;

   typedef enum logic [2:0] {
      KIND_SYMBOL      = 3'd0,
      KIND_FILL        = 3'd1,
      KIND_DONE        = 3'd2,
      KIND_SYNTAX      = 3'd3,
      KIND_UNSUPPORTED = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_LEN_LO  = 3'd1,
      PH_CLASS   = 3'd2,
      PH_COUNTS  = 3'd3,
      PH_SYMBOLS = 3'd4
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       segment_start;
   } req_type;

   typedef struct packed {
      kind_type    kind;
      logic [1:0]  dest_table;
      logic [4:0]  code_bits;
      logic [15:0] code;
      logic [7:0]  symbol;
      logic [9:0]  first_index;
      logic [9:0]  entry_count;
      logic        last;
   } rsp_type;

endpackage

`default_nettype wire

FILE: hdl/jpeg_huffman_table_builder.sv
`timescale 1ns / 1ps
`default_nettype none

// Builds canonical huffman codes from the bytes of a JPEG huffman-table
// segment, fed one byte per request starting at the high length byte
// (segment_start set). Each accepted byte is decoded against the parser
// state in the cycle it is accepted and its results (at most three: symbol
// code, empty fill range, segment done; or a single error) go to the output
// bundle, or to the skid bundle while that one is busy; from a free output
// bundle the first result is offered on rsp the cycle after acceptance. The
// rsp side drains one result per cycle while rsp_stall is low. A byte can
// be accepted every cycle if rsp does not stall and each byte causes at
// most one result; a table's last byte gives up to three results, and a
// one-bundle skid register absorbs the next byte before req_stall rises.
// Reset clears parser state; the sixteen count entries need no clearing.

module jpeg_huffman_table_builder (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire jhtb_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output jhtb_pkg::rsp_type     rsp_data
);

   import jhtb_pkg::*;

   // Parser state
   phase_type   phase_ff, phase_in;
   logic [7:0]  length_high_ff, length_high_in;
   logic [15:0] segment_left_ff, segment_left_in;
   logic [4:0]  header_index_ff, header_index_in;
   logic [1:0]  current_table_ff, current_table_in;
   logic [4:0]  current_length_ff, current_length_in;
   logic [7:0]  left_at_length_ff, left_at_length_in;
   logic [15:0] running_code_ff, running_code_in;
   logic [9:0]  fast_left_ff, fast_left_in;
   logic [11:0] total_ff, total_in;
   logic [USED_W-1:0] used_ff, used_in;
   logic [7:0]  counts_ff [NUM_LENGTHS];

   // Output bundle and skid bundle
   rsp_type     out_ff [MAX_RESULTS];
   rsp_type     out_in [MAX_RESULTS];
   logic [1:0]  out_cnt_ff, out_cnt_in;
   rsp_type     skid_ff [MAX_RESULTS];
   rsp_type     skid_in [MAX_RESULTS];
   logic [1:0]  skid_cnt_ff, skid_cnt_in;

   // Datapath
   logic        accept;
   logic        pop;
   logic        out_free;
   logic [7:0]  b;
   logic        start;
   logic [15:0] seg_dec;
   logic [15:0] len_full;
   logic [4:0]  hidx_inc;
   logic [7:0]  cnt_view [NUM_LENGTHS];
   logic [15:0] nz_mask;
   logic [15:0] above;
   logic [4:0]  search_from;
   logic [4:0]  nl;
   logic [4:0]  nl_dec;
   logic [7:0]  left_pick;
   logic [11:0] total_new;
   logic [USED_W-1:0] used_add;
   logic [USED_W-1:0] used_new;
   logic        count_fail;
   logic        sym_fast;
   logic [9:0]  sym_cnt;
   logic [9:0]  sym_first;
   logic [9:0]  fast_after_sym;
   logic [7:0]  left_dec;
   logic [15:0] code_step;
   logic [9:0]  fill_fast;

   // Events of the accepted byte
   logic        ev_syntax;
   logic        ev_unsup;
   logic        ev_done;
   logic        ev_sym;
   logic        ev_fill;

   // Packed results
   rsp_type     res [MAX_RESULTS];
   logic [1:0]  res_cnt;

   assign b         = req_data.data_byte;
   assign start     = req_data.segment_start;
   assign req_stall = (skid_cnt_ff != 2'd0);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = (out_cnt_ff != 2'd0);
   assign rsp_data  = out_ff[0];
   assign pop       = rsp_valid && !rsp_stall;
   assign out_free  = (out_cnt_ff == 2'd0) || (pop && out_cnt_ff == 2'd1);

   // Shared byte datapath
   always_comb begin
      seg_dec  = (segment_left_ff != 16'd0) ? segment_left_ff - 16'd1 : segment_left_ff;
      len_full = {length_high_ff, b};
      hidx_inc = header_index_ff + 5'd1;

      // Counts as seen this cycle: the last count byte bypasses the store
      for (int i = 0; i < NUM_LENGTHS; i++) begin
         cnt_view[i] = counts_ff[i];
      end
      if (phase_ff == PH_COUNTS) begin
         cnt_view[NUM_LENGTHS-1] = b;
      end
      for (int i = 0; i < NUM_LENGTHS; i++) begin
         nz_mask[i] = (cnt_view[i] != 8'd0);
      end

      // Next used length above the current one (the shortest one in the counts phase)
      search_from = (phase_ff == PH_SYMBOLS) ? current_length_ff : 5'd0;
      above       = nz_mask & (16'hFFFF << search_from);
      nl          = 5'd0;
      for (int i = NUM_LENGTHS - 1; i >= 0; i--) begin
         if (above[i]) begin
            nl = 5'(i + 1);
         end
      end
      nl_dec    = nl - 5'd1;
      left_pick = cnt_view[nl_dec[3:0]];

      // Header totals
      total_new = total_ff + 12'(b);
      if (hidx_inc <= 5'(FAST_BITS)) begin
         used_add = USED_W'(b) << (5'(FAST_BITS) - hidx_inc);
      end else begin
         used_add = '0;
      end
      used_new   = used_ff + used_add;
      count_fail = ({4'd0, total_new} > seg_dec) || (used_new > USED_W'(FAST_SIZE));

      // Symbol code and fast range
      sym_fast = (current_length_ff <= 5'(FAST_BITS));
      if (sym_fast) begin
         sym_cnt   = 10'd1 << (5'(FAST_BITS) - current_length_ff);
         sym_first = 10'(FAST_SIZE) - fast_left_ff;
      end else begin
         sym_cnt   = 10'd0;
         sym_first = 10'd0;
      end
      fast_after_sym = (sym_cnt <= fast_left_ff) ? fast_left_ff - sym_cnt : 10'd0;
      left_dec  = (left_at_length_ff != 8'd0) ? left_at_length_ff - 8'd1 : 8'd0;
      code_step = 16'd1 << (5'd16 - current_length_ff);
      fill_fast = (phase_ff == PH_SYMBOLS) ? fast_after_sym : fast_left_ff;
   end

   // Decide which results the byte causes
   always_comb begin
      ev_syntax = 1'b0;
      ev_unsup  = 1'b0;
      ev_done   = 1'b0;
      ev_sym    = 1'b0;
      ev_fill   = 1'b0;
      if (!start) begin
         case (phase_ff)
            PH_LEN_LO: begin
               if (len_full < 16'd2) begin
                  ev_syntax = 1'b1;
               end else if (len_full == 16'd2) begin
                  ev_done = 1'b1;
               end
            end
            PH_CLASS: begin
               if ((b & CLASS_RESERVED) != 8'd0) begin
                  ev_syntax = 1'b1;
               end else if ((b & CLASS_UNSUPP) != 8'd0) begin
                  ev_unsup = 1'b1;
               end else if (seg_dec == 16'd0) begin
                  ev_syntax = 1'b1;
               end
            end
            PH_COUNTS: begin
               if (!hidx_inc[4]) begin
                  ev_syntax = (seg_dec == 16'd0);
               end else if (count_fail) begin
                  ev_syntax = 1'b1;
               end else if (nl == 5'd0) begin
                  ev_fill = 1'b1;
                  ev_done = (seg_dec == 16'd0);
               end
            end
            PH_SYMBOLS: begin
               ev_sym = 1'b1;
               if (left_dec == 8'd0 && nl == 5'd0) begin
                  ev_fill = 1'b1;
                  ev_done = (seg_dec == 16'd0);
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Pack results in order: symbol, fill, done or error
   always_comb begin
      rsp_type item;
      item    = '0;
      res_cnt = 2'd0;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         res[i] = '0;
      end
      if (ev_sym) begin
         item             = '0;
         item.kind        = KIND_SYMBOL;
         item.dest_table  = current_table_ff;
         item.code_bits   = current_length_ff;
         item.code        = running_code_ff;
         item.symbol      = b;
         item.first_index = sym_first;
         item.entry_count = sym_cnt;
         res[res_cnt]     = item;
         res_cnt          = res_cnt + 2'd1;
      end
      if (ev_fill) begin
         item             = '0;
         item.kind        = KIND_FILL;
         item.dest_table  = current_table_ff;
         item.first_index = 10'(FAST_SIZE) - fill_fast;
         item.entry_count = fill_fast;
         res[res_cnt]     = item;
         res_cnt          = res_cnt + 2'd1;
      end
      if (ev_done || ev_syntax || ev_unsup) begin
         item = '0;
         if (ev_syntax) begin
            item.kind = KIND_SYNTAX;
         end else if (ev_unsup) begin
            item.kind = KIND_UNSUPPORTED;
         end else begin
            item.kind = KIND_DONE;
         end
         res[res_cnt] = item;
         res_cnt      = res_cnt + 2'd1;
      end
      if (res_cnt != 2'd0) begin
         res[res_cnt - 2'd1].last = 1'b1;
      end
   end

   // Next parser state
   always_comb begin
      phase_in          = phase_ff;
      length_high_in    = length_high_ff;
      segment_left_in   = segment_left_ff;
      header_index_in   = header_index_ff;
      current_table_in  = current_table_ff;
      current_length_in = current_length_ff;
      left_at_length_in = left_at_length_ff;
      running_code_in   = running_code_ff;
      fast_left_in      = fast_left_ff;
      total_in          = total_ff;
      used_in           = used_ff;
      if (accept) begin
         if (start) begin
            length_high_in = b;
            phase_in       = PH_LEN_LO;
         end else begin
            case (phase_ff)
               PH_LEN_LO: begin
                  if (len_full <= 16'd2) begin
                     phase_in = PH_IDLE;
                  end else begin
                     segment_left_in = len_full - 16'd2;
                     phase_in        = PH_CLASS;
                  end
               end
               PH_CLASS: begin
                  segment_left_in = seg_dec;
                  if (ev_syntax || ev_unsup) begin
                     phase_in = PH_IDLE;
                  end else begin
                     phase_in = PH_COUNTS;
                  end
                  if (!ev_unsup && (b & CLASS_RESERVED) == 8'd0) begin
                     current_table_in = b[1:0] | b[4:3];
                     header_index_in  = 5'd0;
                     fast_left_in     = 10'(FAST_SIZE);
                     total_in         = 12'd0;
                     used_in          = '0;
                  end
               end
               PH_COUNTS: begin
                  segment_left_in = seg_dec;
                  header_index_in = hidx_inc;
                  total_in        = total_new;
                  used_in         = used_new;
                  if (ev_syntax) begin
                     phase_in = PH_IDLE;
                  end else if (hidx_inc[4]) begin
                     running_code_in   = 16'd0;
                     current_length_in = nl;
                     if (nl == 5'd0) begin
                        fast_left_in = 10'd0;
                        phase_in     = ev_done ? PH_IDLE : PH_CLASS;
                     end else begin
                        left_at_length_in = left_pick;
                        phase_in          = PH_SYMBOLS;
                     end
                  end
               end
               PH_SYMBOLS: begin
                  segment_left_in   = seg_dec;
                  fast_left_in      = fast_after_sym;
                  running_code_in   = running_code_ff + code_step;
                  left_at_length_in = left_dec;
                  if (left_dec == 8'd0) begin
                     current_length_in = nl;
                     if (nl == 5'd0) begin
                        fast_left_in = 10'd0;
                        phase_in     = ev_done ? PH_IDLE : PH_CLASS;
                     end else begin
                        left_at_length_in = left_pick;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   // Next output and skid bundles
   always_comb begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
         out_in[i]  = out_ff[i];
         skid_in[i] = skid_ff[i];
      end
      out_cnt_in  = out_cnt_ff;
      skid_cnt_in = skid_cnt_ff;
      if (out_free) begin
         if (skid_cnt_ff != 2'd0) begin
            out_in      = skid_ff;
            out_cnt_in  = skid_cnt_ff;
            skid_cnt_in = 2'd0;
         end else if (accept && res_cnt != 2'd0) begin
            out_in     = res;
            out_cnt_in = res_cnt;
         end else begin
            out_cnt_in = 2'd0;
         end
      end else begin
         if (pop) begin
            for (int i = 0; i < MAX_RESULTS - 1; i++) begin
               out_in[i] = out_ff[i + 1];
            end
            out_cnt_in = out_cnt_ff - 2'd1;
         end
         if (accept && res_cnt != 2'd0) begin
            skid_in     = res;
            skid_cnt_in = res_cnt;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_IDLE;
         length_high_ff    <= 8'd0;
         segment_left_ff   <= 16'd0;
         header_index_ff   <= 5'd0;
         current_table_ff  <= 2'd0;
         current_length_ff <= 5'd0;
         left_at_length_ff <= 8'd0;
         running_code_ff   <= 16'd0;
         fast_left_ff      <= 10'(FAST_SIZE);
         total_ff          <= 12'd0;
         used_ff           <= '0;
         out_cnt_ff        <= 2'd0;
         skid_cnt_ff       <= 2'd0;
      end else begin
         phase_ff          <= phase_in;
         length_high_ff    <= length_high_in;
         segment_left_ff   <= segment_left_in;
         header_index_ff   <= header_index_in;
         current_table_ff  <= current_table_in;
         current_length_ff <= current_length_in;
         left_at_length_ff <= left_at_length_in;
         running_code_ff   <= running_code_in;
         fast_left_ff      <= fast_left_in;
         total_ff          <= total_in;
         used_ff           <= used_in;
         out_cnt_ff        <= out_cnt_in;
         skid_cnt_ff       <= skid_cnt_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   // Store the code-length counts
   always_ff @(posedge clock) begin
      if (accept && !start && phase_ff == PH_COUNTS) begin
         counts_ff[header_index_ff[3:0]] <= b;
      end
   end

`ifndef SYNTHESIS
   // Skid bundle only fills behind a busy output bundle
   assert property (@(posedge clock) disable iff (reset)
      (skid_cnt_ff != 2'd0) |-> (out_cnt_ff != 2'd0))
      else $error("skid bundle holds results while output bundle is empty");

   // Done and error results always close their bundle
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.kind == KIND_DONE || rsp_data.kind == KIND_SYNTAX ||
                     rsp_data.kind == KIND_UNSUPPORTED)) |-> rsp_data.last)
      else $error("terminal result not marked last");

   // Last flag lines up with the bundle count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last == (out_cnt_ff == 2'd1)))
      else $error("last flag disagrees with bundle count");

   // Symbol phase always has a live code length with symbols left
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SYMBOLS) |->
         (current_length_ff != 5'd0 && left_at_length_ff != 8'd0))
      else $error("symbol phase without a pending code length");

   // Fast entries left never exceed the table size
   assert property (@(posedge clock) disable iff (reset)
      fast_left_ff <= 10'(FAST_SIZE))
      else $error("fast entry count out of range");
`endif

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import jhtb_pkg::*;

   localparam int RESET_CYCLES   = 5;
   localparam int RANDOM_ITEMS   = 430;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 16;
   localparam int MAX_REPORTS    = 10;

   // How a row of the opening table is checked
   typedef enum logic [1:0] {
      CHK_MODEL  = 2'd0,
      CHK_QUIET  = 2'd1,
      CHK_SINGLE = 2'd2
   } check_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       segment_start;
      check_type  check;
      kind_type   lone_kind;
   } plan_row_type;

   localparam int PLAN_ROWS = 21;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   req_type req_data = '0;
   logic    req_stall;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // Segment parser mirror
   phase_type  dht_phase = PH_IDLE;
   logic [7:0] len_high = 8'd0;
   int         seg_left = 0;
   int         hdr_idx = 0;
   logic [1:0] cur_table = 2'd0;
   int         len_counts [NUM_LENGTHS];
   int         cur_len = 0;
   int         left_at = 0;
   int         run_code = 0;
   int         fast_free = FAST_SIZE;

   rsp_type    byte_results [$];
   rsp_type    dht_results_due [$];
   req_type    segment_plan [$];

   int         mismatches = 0;
   int         items_sent = 0;
   int         burst_left = 0;
   int         idle_cycles = 0;
   int         stall_mode = 0;
   int         stall_span = 0;

   // Short segments, bad lengths, bad class bytes and truncated headers
   plan_row_type opening_plan [PLAN_ROWS] = '{
      '{8'hAB, 1'b0, CHK_QUIET,  KIND_SYMBOL},
      '{8'h00, 1'b1, CHK_QUIET,  KIND_SYMBOL},
      '{8'h01, 1'b0, CHK_SINGLE, KIND_SYNTAX},
      '{8'h7F, 1'b1, CHK_QUIET,  KIND_SYMBOL},
      '{8'h00, 1'b1, CHK_QUIET,  KIND_SYMBOL},
      '{8'h02, 1'b0, CHK_SINGLE, KIND_DONE},
      '{8'hFF, 1'b1, CHK_QUIET,  KIND_SYMBOL},
      '{8'hFF, 1'b0, CHK_QUIET,  KIND_SYMBOL},
      '{8'hEC, 1'b0, CHK_SINGLE, KIND_SYNTAX},
      '{8'h00, 1'b0, CHK_QUIET,  KIND_SYMBOL},
      '{8'h00, 1'b1, CHK_QUIET,  KIND_SYMBOL},
      '{8'h20, 1'b0, CHK_QUIET,  KIND_SYMBOL},
      '{8'h02, 1'b0, CHK_SINGLE, KIND_UNSUPPORTED},
      '{8'h00, 1'b1, CHK_QUIET,  KIND_SYMBOL},
      '{8'h03, 1'b0, CHK_QUIET,  KIND_SYMBOL},
      '{8'h10, 1'b0, CHK_SINGLE, KIND_SYNTAX},
      '{8'h00, 1'b1, CHK_QUIET,  KIND_SYMBOL},
      '{8'h05, 1'b0, CHK_QUIET,  KIND_SYMBOL},
      '{8'h01, 1'b0, CHK_QUIET,  KIND_SYMBOL},
      '{8'h00, 1'b0, CHK_QUIET,  KIND_SYMBOL},
      '{8'h00, 1'b0, CHK_SINGLE, KIND_SYNTAX}
   };

   jpeg_huffman_table_builder DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #4 clock = ~clock;

   function automatic logic [7:0] rand_byte();
      int v;
      v = $urandom_range(0, 255);
      return v[7:0];
   endfunction

   function automatic req_type seg_byte(logic [7:0] d, logic s);
      req_type r;
      r.data_byte = d;
      r.segment_start = s;
      return r;
   endfunction

   function automatic rsp_type lone_result(kind_type k);
      rsp_type r;
      r = '0;
      r.kind = k;
      r.last = 1'b1;
      return r;
   endfunction

   function automatic string show(rsp_type r);
      return $sformatf("kind=%0d table=%0d len=%0d code=%h sym=%h first=%0d count=%0d last=%0b",
                       r.kind, r.dest_table, r.code_bits, r.code, r.symbol, r.first_index,
                       r.entry_count, r.last);
   endfunction

   function automatic void add_result(kind_type k, logic [1:0] t, int len, int cd,
                                      logic [7:0] sym, int first, int cnt);
      rsp_type r;
      r.kind = k;
      r.dest_table = t;
      r.code_bits = len[4:0];
      r.code = cd[15:0];
      r.symbol = sym;
      r.first_index = first[9:0];
      r.entry_count = cnt[9:0];
      r.last = 1'b0;
      byte_results = {byte_results, r};
   endfunction

   // Report an error and drop back to idle until the next segment start
   function automatic void fault(kind_type k);
      add_result(k, 2'd0, 0, 0, 8'd0, 0, 0);
      dht_phase = PH_IDLE;
   endfunction

   // Shortest code length above 'from' that has symbols, 0 when none is left
   function automatic int shortest_after(int from);
      for (int l = from + 1; l <= NUM_LENGTHS; l++)
         if (len_counts[l - 1] != 0) return l;
      return 0;
   endfunction

   // Emit the unused fast entries, then either end the segment or expect a class byte
   function automatic void close_table();
      add_result(KIND_FILL, cur_table, 0, 0, 8'd0, FAST_SIZE - fast_free, fast_free);
      fast_free = 0;
      if (seg_left == 0) begin
         add_result(KIND_DONE, 2'd0, 0, 0, 8'd0, 0, 0);
         dht_phase = PH_IDLE;
      end else begin
         dht_phase = PH_CLASS;
      end
   endfunction

   // Advance the parser mirror by one segment byte; returns 0 for an ignored stray byte
   function automatic bit decode_dht_byte(req_type item);
      logic [7:0] b;
      logic [7:0] folded;
      int         seg_len;
      int         total;
      int         used;
      int         len;
      int         cnt;
      int         first;
      b = item.data_byte;
      byte_results.delete();
      if (item.segment_start) begin
         len_high = b;
         dht_phase = PH_LEN_LO;
         return 1'b1;
      end
      if (dht_phase == PH_IDLE) return 1'b0;
      case (dht_phase)
         PH_LEN_LO: begin
            seg_len = {len_high, b};
            if (seg_len < 2) begin
               fault(KIND_SYNTAX);
            end else if (seg_len == 2) begin
               add_result(KIND_DONE, 2'd0, 0, 0, 8'd0, 0, 0);
               dht_phase = PH_IDLE;
            end else begin
               seg_left = seg_len - 2;
               dht_phase = PH_CLASS;
            end
         end
         PH_CLASS: begin
            if (seg_left > 0) seg_left--;
            if ((b & CLASS_RESERVED) != 8'd0) begin
               fault(KIND_SYNTAX);
            end else if ((b & CLASS_UNSUPP) != 8'd0) begin
               fault(KIND_UNSUPPORTED);
            end else begin
               folded = b | (b >> 3);
               cur_table = folded[1:0];
               hdr_idx = 0;
               fast_free = FAST_SIZE;
               if (seg_left == 0) fault(KIND_SYNTAX);
               else dht_phase = PH_COUNTS;
            end
         end
         PH_COUNTS: begin
            if (seg_left > 0) seg_left--;
            len_counts[hdr_idx % NUM_LENGTHS] = b;
            hdr_idx = (hdr_idx + 1) % 32;
            if (hdr_idx < NUM_LENGTHS) begin
               if (seg_left == 0) fault(KIND_SYNTAX);
            end else begin
               // Check symbol total against the segment and the fast table budget
               total = 0;
               used = 0;
               for (int l = 1; l <= NUM_LENGTHS; l++) begin
                  total += len_counts[l - 1];
                  if (l <= FAST_BITS) used += len_counts[l - 1] << (FAST_BITS - l);
               end
               if (total > seg_left || used > FAST_SIZE) begin
                  fault(KIND_SYNTAX);
               end else begin
                  run_code = 0;
                  cur_len = shortest_after(0);
                  if (cur_len == 0) begin
                     close_table();
                  end else begin
                     left_at = len_counts[cur_len - 1];
                     dht_phase = PH_SYMBOLS;
                  end
               end
            end
         end
         PH_SYMBOLS: begin
            len = cur_len;
            cnt = 0;
            first = 0;
            if (len < 1 || len > NUM_LENGTHS) begin
               fault(KIND_SYNTAX);
            end else begin
               if (seg_left > 0) seg_left--;
               if (len <= FAST_BITS) begin
                  cnt = 1 << (FAST_BITS - len);
                  first = FAST_SIZE - fast_free;
               end
               add_result(KIND_SYMBOL, cur_table, len, run_code, b, first, cnt);
               fast_free = (cnt <= fast_free) ? fast_free - cnt : 0;
               // Canonical code step, wrapping at 16 bits
               run_code = (run_code + (1 << (16 - len))) & 32'hFFFF;
               if (left_at > 0) left_at--;
               if (left_at == 0) begin
                  cur_len = shortest_after(len);
                  if (cur_len == 0) close_table();
                  else left_at = len_counts[cur_len - 1];
               end
            end
         end
         default: ;
      endcase
      if (byte_results.size() > 0) begin
         byte_results[byte_results.size() - 1].last = 1'b1;
      end
      return 1'b1;
   endfunction

   // Build one segment: mostly well formed, some truncated, padded, corrupted or noise
   function automatic void plan_segment();
      req_type    body [$];
      int         counts [NUM_LENGTHS];
      int         flavor;
      int         n_tables;
      int         n_sym;
      int         total;
      int         l;
      int         used;
      int         seg_len;
      int         extra;
      int         cut;
      logic [7:0] cls;
      segment_plan.delete();
      flavor = $urandom_range(0, 99);
      if (flavor >= 97) begin
         repeat ($urandom_range(4, 8))
            segment_plan = {segment_plan,
                            seg_byte(rand_byte(), $urandom_range(0, 3) == 0)};
         return;
      end
      n_tables = $urandom_range(1, 3);
      for (int t = 0; t < n_tables; t++) begin
         cls = 8'h00;
         cls[4] = ($urandom_range(0, 1) == 1);
         cls[0] = ($urandom_range(0, 1) == 1);
         body = {body, seg_byte(cls, 1'b0)};
         foreach (counts[i]) counts[i] = 0;
         used = 0;
         // Sometimes fill the fast table with two 1-bit codes so longer codes wrap
         if ($urandom_range(0, 5) == 0) begin
            counts[0] = 2;
            used = FAST_SIZE;
         end
         n_sym = $urandom_range(0, 12);
         for (int s = 0; s < n_sym; s++) begin
            l = $urandom_range(1, NUM_LENGTHS);
            if (l <= FAST_BITS && used + (1 << (FAST_BITS - l)) > FAST_SIZE)
               l = $urandom_range(FAST_BITS + 1, NUM_LENGTHS);
            counts[l - 1]++;
            if (l <= FAST_BITS) used += 1 << (FAST_BITS - l);
         end
         total = 0;
         foreach (counts[i]) begin
            body = {body, seg_byte(counts[i][7:0], 1'b0)};
            total += counts[i];
         end
         repeat (total) body = {body, seg_byte(rand_byte(), 1'b0)};
      end
      seg_len = 2 + body.size();
      if (flavor >= 70 && flavor < 78) begin
         seg_len -= $urandom_range(1, body.size());
      end else if (flavor >= 78 && flavor < 84) begin
         extra = $urandom_range(1, 3);
         seg_len += extra;
         repeat (extra) body = {body, seg_byte(rand_byte(), 1'b0)};
      end else if (flavor >= 84 && flavor < 89) begin
         body[0] = seg_byte(rand_byte(), 1'b0);
      end else if (flavor >= 89 && flavor < 93) begin
         body[$urandom_range(1, NUM_LENGTHS)] = seg_byte(rand_byte(), 1'b0);
      end else if (flavor >= 93) begin
         // Abandon the segment partway; the next start aborts it
         cut = $urandom_range(1, body.size() - 1);
         while (body.size() > cut) void'(body.pop_back());
      end
      segment_plan = {segment_plan, seg_byte(seg_len[15:8], 1'b1)};
      segment_plan = {segment_plan, seg_byte(seg_len[7:0], 1'b0)};
      segment_plan = {segment_plan, body};
   endfunction

   // Offer one request, wait for its acceptance, then queue what it should produce
   task automatic send_byte(input req_type item, input check_type chk, input kind_type lone_kind,
                            input bit drain);
      int gap;
      bit counted;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
      burst_left--;
      if (drain || gap > 0) begin
         req_valid <= 1'b0;
         @(posedge clock);
         if (drain) begin
            while (dht_results_due.size() != 0) @(posedge clock);
         end else begin
            repeat (gap - 1) @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      counted = decode_dht_byte(item);
      case (chk)
         CHK_MODEL:  dht_results_due = {dht_results_due, byte_results};
         CHK_SINGLE: dht_results_due = {dht_results_due, lone_result(lone_kind)};
         default:    ;
      endcase
      if (counted) items_sent++;
   endtask

   // Receiver stall pattern: switch between no stall, light and heavy stalling
   always @(posedge clock) begin
      if (stall_span == 0) begin
         stall_mode <= $urandom_range(0, 2);
         stall_span <= $urandom_range(20, 120);
      end else begin
         stall_span <= stall_span - 1;
      end
      case (stall_mode)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= ($urandom_range(0, 1) == 1);
         default: rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
   end

   // Compare each accepted result with the oldest one due
   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (dht_results_due.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("tb_top: unexpected result %s", show(rsp_data));
         end else begin
            want = dht_results_due.pop_front();
            if (rsp_data !== want) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display("tb_top: mismatch expected %s", show(want));
                  $display("tb_top:          actual   %s", show(rsp_data));
               end
            end
         end
      end
   end

   // Watchdog: end the run when neither side moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      bit first_seg;
      bit pause;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the opening table
      foreach (opening_plan[i])
         send_byte(seg_byte(opening_plan[i].data_byte, opening_plan[i].segment_start),
                   opening_plan[i].check, opening_plan[i].lone_kind, 1'b0);

      // Random segments; hold the sender until drained at the first and now and then
      items_sent = 0;
      first_seg = 1'b1;
      while (items_sent < RANDOM_ITEMS) begin
         plan_segment();
         pause = first_seg || ($urandom_range(0, 7) == 0);
         first_seg = 1'b0;
         foreach (segment_plan[i])
            send_byte(segment_plan[i], CHK_MODEL, KIND_SYMBOL, pause && i == 0);
      end
      req_valid <= 1'b0;

      // Drain, then give stray results time to show up
      @(posedge clock);
      while (dht_results_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && dht_results_due.size() == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule

FILE: jpeg_huffman_table_builder.f
hdl/jhtb_pkg.sv
hdl/jpeg_huffman_table_builder.sv
tb/tb_top.sv
